// ----- sv/dklt_pkg.sv -----
// dklt_pkg: shared types and codes for the dual key lookup table
// no dependencies; imported by dklt_match and dual_key_lookup_table
`default_nettype none

package dklt_pkg;

    // command codes of an input item
    typedef enum logic [1:0] {
        CMD_INSERT     = 2'd0,
        CMD_LOOKUP_PRI = 2'd1,
        CMD_LOOKUP_SEC = 2'd2,
        CMD_UNUSED     = 2'd3
    } cmd_t;

    // status codes of a result item
    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_NO_KEY          = 3'd1,
        ST_PRIMARY_TAKEN   = 3'd2,
        ST_SECONDARY_TAKEN = 3'd3,
        ST_NOT_FOUND       = 3'd4,
        ST_FULL            = 3'd5
    } status_t;

    // compare unit result for one stored entry
    typedef struct packed {
        logic prim_hit;
        logic sec_hit;
    } match_t;

endpackage

`default_nettype wire

// ----- sv/dklt_if.sv -----
// dklt_if: valid/ready channel interfaces for request and response items
// no dependencies; used by the top level ports
`default_nettype none

interface dklt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic        primary_present;
    logic [31:0] primary_key;
    logic        secondary_present;
    logic [31:0] secondary_key;
    logic [31:0] entry_value;

    modport source (
        output valid, cmd, primary_present, primary_key,
               secondary_present, secondary_key, entry_value,
        input  ready
    );
    modport sink (
        input  valid, cmd, primary_present, primary_key,
               secondary_present, secondary_key, entry_value,
        output ready
    );
endinterface

interface dklt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] found_value;

    modport source (
        output valid, status, found_value,
        input  ready
    );
    modport sink (
        input  valid, status, found_value,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/dklt_store.sv -----
// dklt_store: entry memory, one write port and one registered read port
// no package dependencies; instantiated by dual_key_lookup_table
`default_nettype none

module dklt_store #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int ADDR_W     = 4
) (
    input  wire                   clk,
    input  wire                   wr_en,
    input  wire [ADDR_W-1:0]      wr_addr,
    input  wire                   wr_pvalid,
    input  wire [KEY_BITS-1:0]    wr_pkey,
    input  wire                   wr_svalid,
    input  wire [KEY_BITS-1:0]    wr_skey,
    input  wire [VALUE_BITS-1:0]  wr_value,
    input  wire [ADDR_W-1:0]      rd_addr,
    output logic                  rd_pvalid,
    output logic [KEY_BITS-1:0]   rd_pkey,
    output logic                  rd_svalid,
    output logic [KEY_BITS-1:0]   rd_skey,
    output logic [VALUE_BITS-1:0] rd_value
);

    logic                  pvalid_mem_reg [ENTRIES];
    logic [KEY_BITS-1:0]   pkey_mem_reg   [ENTRIES];
    logic                  svalid_mem_reg [ENTRIES];
    logic [KEY_BITS-1:0]   skey_mem_reg   [ENTRIES];
    logic [VALUE_BITS-1:0] value_mem_reg  [ENTRIES];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pvalid_mem_reg[wr_addr] <= wr_pvalid;
            pkey_mem_reg[wr_addr]   <= wr_pkey;
            svalid_mem_reg[wr_addr] <= wr_svalid;
            skey_mem_reg[wr_addr]   <= wr_skey;
            value_mem_reg[wr_addr]  <= wr_value;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_pvalid <= pvalid_mem_reg[rd_addr];
        rd_pkey   <= pkey_mem_reg[rd_addr];
        rd_svalid <= svalid_mem_reg[rd_addr];
        rd_skey   <= skey_mem_reg[rd_addr];
        rd_value  <= value_mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

// ----- sv/dklt_match.sv -----
// dklt_match: shared key compare unit, checks one stored entry per cycle
// depends on dklt_pkg for match_t
`default_nettype none

module dklt_match #(
    parameter int KEY_BITS = 32
) (
    input  wire                 ent_pvalid,
    input  wire [KEY_BITS-1:0]  ent_pkey,
    input  wire                 ent_svalid,
    input  wire [KEY_BITS-1:0]  ent_skey,
    input  wire [KEY_BITS-1:0]  pkey,
    input  wire [KEY_BITS-1:0]  skey,
    output dklt_pkg::match_t    match
);

    import dklt_pkg::*;

    // both key compares of the entry under scan
    always_comb
    begin
        match.prim_hit = ent_pvalid && (ent_pkey == pkey);
        match.sec_hit  = ent_svalid && (ent_skey == skey);
    end

endmodule

`default_nettype wire

// ----- sv/dual_key_lookup_table.sv -----
// dual_key_lookup_table: one request item in, one response item out.
// a request is accepted only in idle; each stored entry is then compared in turn
// through the shared compare unit, then the decide step registers the response.
// a new request is taken only after the decide step of the last one; a held
// response stalls the decide step. reset empties the table (fill count to
// zero); entry memory is not cleared and needs no clearing pass.
`default_nettype none

module dual_key_lookup_table #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    dklt_in_if.sink     req,
    dklt_out_if.source  rsp
);

    import dklt_pkg::*;

    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [ADDR_W-1:0]     idx_reg, idx_next;
    logic                  rd_pend_reg, rd_pend_next;
    cmd_t                  cmd_reg, cmd_next;
    logic                  pp_reg, pp_next;
    logic                  sp_reg, sp_next;
    logic [KEY_BITS-1:0]   pk_reg, pk_next;
    logic [KEY_BITS-1:0]   sk_reg, sk_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  phit_reg, phit_next;
    logic                  shit_reg, shit_next;
    logic                  lhit_reg, lhit_next;
    logic [VALUE_BITS-1:0] lval_reg, lval_next;
    logic                  out_valid_reg, out_valid_next;
    status_t               status_reg, status_next;
    logic [31:0]           found_reg, found_next;

    logic                  wr_en;
    logic                  rd_pvalid;
    logic [KEY_BITS-1:0]   rd_pkey;
    logic                  rd_svalid;
    logic [KEY_BITS-1:0]   rd_skey;
    logic [VALUE_BITS-1:0] rd_value;
    match_t                match;
    logic                  cur_lhit;
    logic                  out_free;
    logic                  scan_last;

    // entry memory
    dklt_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .ADDR_W     (ADDR_W)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (fill_reg[ADDR_W-1:0]),
        .wr_pvalid (pp_reg),
        .wr_pkey   (pk_reg),
        .wr_svalid (sp_reg),
        .wr_skey   (sk_reg),
        .wr_value  (val_reg),
        .rd_addr   (idx_reg),
        .rd_pvalid (rd_pvalid),
        .rd_pkey   (rd_pkey),
        .rd_svalid (rd_svalid),
        .rd_skey   (rd_skey),
        .rd_value  (rd_value)
    );

    // shared compare unit
    dklt_match #(
        .KEY_BITS (KEY_BITS)
    ) u_match (
        .ent_pvalid (rd_pvalid),
        .ent_pkey   (rd_pkey),
        .ent_svalid (rd_svalid),
        .ent_skey   (rd_skey),
        .pkey       (pk_reg),
        .skey       (sk_reg),
        .match      (match)
    );

    // handshake outputs
    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found_value = found_reg;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign scan_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == fill_reg);

    // lookup hit on the entry now leaving the memory
    always_comb
    begin
        case (cmd_reg)
            CMD_LOOKUP_PRI: cur_lhit = rd_pend_reg && match.prim_hit;
            CMD_LOOKUP_SEC: cur_lhit = rd_pend_reg && match.sec_hit;
            default:        cur_lhit = 1'b0;
        endcase
    end

    // sequencer and next state
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        rd_pend_next   = 1'b0;
        cmd_next       = cmd_reg;
        pp_next        = pp_reg;
        sp_next        = sp_reg;
        pk_next        = pk_reg;
        sk_next        = sk_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        found_next     = found_reg;
        wr_en          = 1'b0;

        // fold in the compare of the entry read last cycle
        phit_next = phit_reg || (rd_pend_reg && match.prim_hit);
        shit_next = shit_reg || (rd_pend_reg && match.sec_hit);
        lhit_next = lhit_reg || cur_lhit;
        lval_next = (cur_lhit && !lhit_reg) ? rd_value : lval_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = cmd_t'(req.cmd);
                    pp_next    = req.primary_present;
                    sp_next    = req.secondary_present;
                    pk_next    = KEY_BITS'(req.primary_key);
                    sk_next    = KEY_BITS'(req.secondary_key);
                    val_next   = VALUE_BITS'(req.entry_value);
                    idx_next   = '0;
                    phit_next  = 1'b0;
                    shit_next  = 1'b0;
                    lhit_next  = 1'b0;
                    lval_next  = '0;
                    state_next = (fill_reg == '0) ? S_DECIDE : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // issue one entry read per cycle
                rd_pend_next = 1'b1;
                idx_next     = idx_reg + ADDR_W'(1);
                if (scan_last)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = '0;
                    state_next     = S_IDLE;
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (!pp_reg && !sp_reg)
                            begin
                                status_next = ST_NO_KEY;
                            end
                            else if (pp_reg && phit_next)
                            begin
                                status_next = ST_PRIMARY_TAKEN;
                            end
                            else if (sp_reg && shit_next)
                            begin
                                status_next = ST_SECONDARY_TAKEN;
                            end
                            else if (fill_reg == CNT_W'(ENTRIES))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                wr_en       = 1'b1;
                                fill_next   = fill_reg + CNT_W'(1);
                            end
                        end
                        CMD_LOOKUP_PRI, CMD_LOOKUP_SEC:
                        begin
                            if (lhit_next)
                            begin
                                status_next = ST_OK;
                                found_next  = 32'(lval_next);
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and scan flags
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        pp_reg     <= pp_next;
        sp_reg     <= sp_next;
        pk_reg     <= pk_next;
        sk_reg     <= sk_next;
        val_reg    <= val_next;
        phit_reg   <= phit_next;
        shit_reg   <= shit_next;
        lhit_reg   <= lhit_next;
        lval_reg   <= lval_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

endmodule

`default_nettype wire
